// ----- hw/rtl/pfm_pkg.sv -----
// types and character constants shared by the float-map header parser
package pfm_pkg;

  // width of the dimension and length fields on the result channel
  localparam int unsigned FIELD_BITS = 32;

  // parse phases
  typedef enum logic [3:0] {
    PH_P       = 4'd0,
    PH_F       = 4'd1,
    PH_WS1     = 4'd2,
    PH_W_FIRST = 4'd3,
    PH_W_MORE  = 4'd4,
    PH_H_FIRST = 4'd5,
    PH_H_MORE  = 4'd6,
    PH_S_START = 4'd7,
    PH_S_INT   = 4'd8,
    PH_S_FRAC  = 4'd9
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_EARLY_END  = 3'd2,
    ST_NO_DIGIT   = 3'd3,
    ST_NO_BLANK   = 3'd4,
    ST_NO_WS      = 3'd5,
    ST_NO_SIGN    = 3'd6,
    ST_BAD_SCALE  = 3'd7
  } status_e;

  // class of the integer part of the scale seen so far
  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_LARGE = 2'd2
  } scale_cls_e;

  // characters of interest
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // whitespace test
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE);
  endfunction

  // decimal digit test
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- hw/rtl/pfm_header_parser_core.sv -----
// float-map header parser: byte-serial header check with width, height and endianness
//
// The input channel carries one file byte per request (data_byte_i) with first_byte_i
// marking the start of a new file and last_byte_i the end of the buffer. The output
// channel carries at most one result per file: status, width, height, endianness and
// header length, or an error status with all other fields zero. After a result the
// block swallows bytes without reply until the next first_byte_i.
// Throughput is one byte per cycle unless a second result is held back by out_stall_i:
// each byte passes through an input register and one step of the parse logic (a x10
// accumulate on shifts and adds) into the result register.
// The result register lets the next byte enter while a result waits; a byte that would
// produce a second result is held in the input register while out_stall_i is high,
// and in_stall_o then rises. Bytes that produce no result keep flowing.
// Reset clears both registers' valid flags and returns the parser to waiting for 'P',
// so a stream may start without first_byte_i.
module pfm_header_parser_core #(
  parameter int unsigned DIM_BITS   = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            first_byte_i,
  input  logic                            last_byte_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      status_o,
  output logic [pfm_pkg::FIELD_BITS-1:0]  image_width_o,
  output logic [pfm_pkg::FIELD_BITS-1:0]  image_height_o,
  output logic                            is_big_endian_o,
  output logic [pfm_pkg::FIELD_BITS-1:0]  header_length_o
);

  localparam logic [DIM_BITS-1:0]   DIM_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;

  // parse state
  pfm_pkg::phase_e     phase_q, phase_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic                neg_q, neg_d;
  pfm_pkg::scale_cls_e cls_q, cls_d;
  logic                frac_nz_q, frac_nz_d;
  logic [COUNT_BITS-1:0] bytes_q, bytes_d;
  logic                done_q, done_d;

  // result register
  logic                           out_valid_q;
  logic [2:0]                     status_q;
  logic [pfm_pkg::FIELD_BITS-1:0] width_out_q, height_out_q, length_out_q;
  logic                           big_q;

  // view of the state after an optional restart
  pfm_pkg::phase_e       phase_cur;
  logic [DIM_BITS-1:0]   width_cur, height_cur;
  logic                  neg_cur, frac_nz_cur, done_cur;
  pfm_pkg::scale_cls_e   cls_cur;
  logic [COUNT_BITS-1:0] bytes_cur, bytes_inc;

  // decision of this byte
  logic            emit;
  pfm_pkg::status_e status_sel;

  // handshake
  logic out_free, proc_go, in_load;

  // decimal accumulate
  logic [3:0]            digit;
  logic [DIM_BITS+3:0]   acc_in, acc_x10;
  logic [DIM_BITS-1:0]   acc_push;

  // result payload
  logic [2:0]                     res_status;
  logic [pfm_pkg::FIELD_BITS-1:0] res_width, res_height, res_length;
  logic                           res_big;
  logic [63:0]                    width_ext, height_ext, length_ext;

  // handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_go    = in_valid_q && (!emit || out_free);
  assign in_load    = !in_valid_q || proc_go;
  assign in_stall_o = !in_load;

  // restart view
  always_comb begin
    phase_cur   = first_q ? pfm_pkg::PH_P : phase_q;
    width_cur   = first_q ? '0 : width_q;
    height_cur  = first_q ? '0 : height_q;
    neg_cur     = first_q ? 1'b0 : neg_q;
    cls_cur     = first_q ? pfm_pkg::CLS_ZERO : cls_q;
    frac_nz_cur = first_q ? 1'b0 : frac_nz_q;
    bytes_cur   = first_q ? '0 : bytes_q;
    done_cur    = first_q ? 1'b0 : done_q;
    bytes_inc   = (bytes_cur == COUNT_MAX) ? bytes_cur : bytes_cur + COUNT_BITS'(1);
  end

  // accumulator push: acc*10 + digit, saturating
  assign digit    = 4'(byte_q - pfm_pkg::CH_ZERO);
  assign acc_in   = (phase_cur == pfm_pkg::PH_W_FIRST || phase_cur == pfm_pkg::PH_W_MORE)
                    ? (DIM_BITS+4)'(width_cur) : (DIM_BITS+4)'(height_cur);
  assign acc_x10  = (acc_in << 3) + (acc_in << 1) + (DIM_BITS+4)'(digit);
  assign acc_push = (acc_x10 > (DIM_BITS+4)'(DIM_MAX)) ? DIM_MAX : acc_x10[DIM_BITS-1:0];

  // next state
  always_comb begin
    phase_d    = phase_cur;
    width_d    = width_cur;
    height_d   = height_cur;
    neg_d      = neg_cur;
    cls_d      = cls_cur;
    frac_nz_d  = frac_nz_cur;
    bytes_d    = bytes_cur;
    done_d     = done_cur;
    emit       = 1'b0;
    status_sel = pfm_pkg::ST_OK;
    if (!done_cur) begin
      bytes_d = bytes_inc;
      case (phase_cur)
        pfm_pkg::PH_P: begin
          if (byte_q != pfm_pkg::CH_P) begin
            emit = 1'b1; status_sel = pfm_pkg::ST_BAD_MAGIC;
          end else begin
            phase_d = pfm_pkg::PH_F;
          end
        end
        pfm_pkg::PH_F: begin
          if (byte_q != pfm_pkg::CH_F) begin
            emit = 1'b1; status_sel = pfm_pkg::ST_BAD_MAGIC;
          end else begin
            phase_d = pfm_pkg::PH_WS1;
          end
        end
        pfm_pkg::PH_WS1: begin
          if (!pfm_pkg::is_ws(byte_q)) begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_WS;
          end else begin
            phase_d = pfm_pkg::PH_W_FIRST;
          end
        end
        pfm_pkg::PH_W_FIRST, pfm_pkg::PH_W_MORE: begin
          if (pfm_pkg::is_digit(byte_q)) begin
            width_d = acc_push;
            phase_d = pfm_pkg::PH_W_MORE;
          end else if (phase_cur == pfm_pkg::PH_W_FIRST) begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_DIGIT;
          end else if (byte_q == pfm_pkg::CH_SPACE || byte_q == pfm_pkg::CH_LF) begin
            phase_d = pfm_pkg::PH_H_FIRST;
          end else begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_BLANK;
          end
        end
        pfm_pkg::PH_H_FIRST, pfm_pkg::PH_H_MORE: begin
          if (pfm_pkg::is_digit(byte_q)) begin
            height_d = acc_push;
            phase_d  = pfm_pkg::PH_H_MORE;
          end else if (phase_cur == pfm_pkg::PH_H_FIRST) begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_DIGIT;
          end else if (pfm_pkg::is_ws(byte_q)) begin
            phase_d = pfm_pkg::PH_S_START;
          end else begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_WS;
          end
        end
        pfm_pkg::PH_S_START, pfm_pkg::PH_S_INT: begin
          if (pfm_pkg::is_digit(byte_q)) begin
            if (cls_cur == pfm_pkg::CLS_ZERO) begin
              if (byte_q == pfm_pkg::CH_ZERO) begin
                cls_d = pfm_pkg::CLS_ZERO;
              end else if (byte_q == pfm_pkg::CH_ONE) begin
                cls_d = pfm_pkg::CLS_ONE;
              end else begin
                cls_d = pfm_pkg::CLS_LARGE;
              end
            end else begin
              cls_d = pfm_pkg::CLS_LARGE;
            end
            phase_d = pfm_pkg::PH_S_INT;
          end else if (phase_cur == pfm_pkg::PH_S_START) begin
            if (byte_q == pfm_pkg::CH_MINUS || byte_q == pfm_pkg::CH_PLUS) begin
              neg_d   = (byte_q == pfm_pkg::CH_MINUS);
              phase_d = pfm_pkg::PH_S_INT;
            end else begin
              emit = 1'b1; status_sel = pfm_pkg::ST_NO_SIGN;
            end
          end else if (byte_q == pfm_pkg::CH_DOT) begin
            phase_d = pfm_pkg::PH_S_FRAC;
          end else if (pfm_pkg::is_ws(byte_q)) begin
            emit       = 1'b1;
            status_sel = (cls_cur == pfm_pkg::CLS_ONE && !frac_nz_cur)
                         ? pfm_pkg::ST_OK : pfm_pkg::ST_BAD_SCALE;
          end else begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_WS;
          end
        end
        pfm_pkg::PH_S_FRAC: begin
          if (pfm_pkg::is_digit(byte_q)) begin
            if (byte_q != pfm_pkg::CH_ZERO) begin
              frac_nz_d = 1'b1;
            end
          end else if (pfm_pkg::is_ws(byte_q)) begin
            emit       = 1'b1;
            status_sel = (cls_cur == pfm_pkg::CLS_ONE && !frac_nz_cur)
                         ? pfm_pkg::ST_OK : pfm_pkg::ST_BAD_SCALE;
          end else begin
            emit = 1'b1; status_sel = pfm_pkg::ST_NO_WS;
          end
        end
        default: begin
          emit = 1'b1; status_sel = pfm_pkg::ST_BAD_MAGIC;
        end
      endcase
      // header unfinished at the end of the buffer
      if (!emit && last_q) begin
        emit       = 1'b1;
        status_sel = pfm_pkg::ST_EARLY_END;
      end
      if (emit) begin
        done_d = 1'b1;
      end
    end
  end

  // result payload
  always_comb begin
    width_ext  = 64'(width_cur);
    height_ext = 64'(height_cur);
    length_ext = 64'(bytes_inc);
    res_status = status_sel;
    if (status_sel == pfm_pkg::ST_OK) begin
      res_width  = width_ext[pfm_pkg::FIELD_BITS-1:0];
      res_height = height_ext[pfm_pkg::FIELD_BITS-1:0];
      res_big    = !neg_cur;
      res_length = length_ext[pfm_pkg::FIELD_BITS-1:0];
    end else begin
      res_width  = '0;
      res_height = '0;
      res_big    = 1'b0;
      res_length = '0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pfm_pkg::PH_P;
      width_q   <= '0;
      height_q  <= '0;
      neg_q     <= 1'b0;
      cls_q     <= pfm_pkg::CLS_ZERO;
      frac_nz_q <= 1'b0;
      bytes_q   <= '0;
      done_q    <= 1'b0;
    end else if (proc_go) begin
      phase_q   <= phase_d;
      width_q   <= width_d;
      height_q  <= height_d;
      neg_q     <= neg_d;
      cls_q     <= cls_d;
      frac_nz_q <= frac_nz_d;
      bytes_q   <= bytes_d;
      done_q    <= done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && emit) begin
      status_q     <= res_status;
      width_out_q  <= res_width;
      height_out_q <= res_height;
      big_q        <= res_big;
      length_out_q <= res_length;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign image_width_o   = width_out_q;
  assign image_height_o  = height_out_q;
  assign is_big_endian_o = big_q;
  assign header_length_o = length_out_q;

endmodule
